// ----- rtl/rkc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reference-counted key cache table package
// Shared request, response and entry types, action and status codes.
// ----------------------------------------------------------------------------
package rkc_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int SLOT_W      = 6;
  localparam int COUNT_W     = 16;
  localparam int DEV_W       = 8;
  localparam int OBJ_W       = 32;
  localparam int LINK_W      = 16;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_DUP    = 2'd1;
  localparam logic [1:0] ACT_PUT    = 2'd2;
  localparam logic [1:0] ACT_LOAD   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_HELD  = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [1:0]        action;
    logic [DEV_W-1:0]  device_id;
    logic [OBJ_W-1:0]  object_number;
    logic [SLOT_W-1:0] slot;
    logic [LINK_W-1:0] link_count;
  } in_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  result_slot;
    logic [1:0]         status;
    logic               hit;
    logic               needs_load;
    logic               release_on_disk;
    logic [COUNT_W-1:0] count_after;
  } out_rsp_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               loaded;
    logic               unlinked;
    logic [DEV_W-1:0]   device_id;
    logic [OBJ_W-1:0]   object_number;
  } entry_t;

  typedef struct packed {
    logic              lk_hit;
    logic              lk_full;
    logic              oor;
    logic [SLOT_W-1:0] tgt_slot;
  } eval_ctl_t;

endpackage

// ----- rtl/rkc_entry_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rkc_entry_ram #(
  parameter int ENTRIES = rkc_pkg::ENTRIES_DEF,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  rkc_pkg::entry_t     wr_data,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output rkc_pkg::entry_t     rd_data
);
  import rkc_pkg::*;

  entry_t mem [ENTRIES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/rkc_eval_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entry evaluation unit
// Key compare during the scan; count update, flag update and response build
// for the entry selected by the sequencer.
// ----------------------------------------------------------------------------
module rkc_eval_unit (
  input  rkc_pkg::eval_ctl_t ctl,
  input  rkc_pkg::in_req_t   req,
  input  rkc_pkg::entry_t    word,
  output logic               match,
  output logic               wr_en,
  output rkc_pkg::entry_t    new_word,
  output rkc_pkg::out_rsp_t  rsp
);
  import rkc_pkg::*;

  logic               held;
  logic               sat;
  logic [COUNT_W-1:0] inc;
  logic [COUNT_W-1:0] dec;
  logic               rel;

  always_comb begin
    held  = (word.count != '0);
    sat   = (word.count == COUNT_MAX);
    inc   = sat ? word.count : word.count + COUNT_W'(1);
    dec   = word.count - COUNT_W'(1);
    rel   = (word.count == COUNT_W'(1)) && word.loaded && word.unlinked;
    match = held && (word.device_id == req.device_id) &&
            (word.object_number == req.object_number);

    new_word        = word;
    wr_en           = 1'b0;
    rsp             = '0;
    rsp.result_slot = ctl.tgt_slot;

    if (req.action == ACT_LOOKUP) begin
      if (ctl.lk_hit) begin
        new_word.count  = inc;
        wr_en           = !sat;
        rsp.status      = sat ? ST_SATURATED : ST_OK;
        rsp.hit         = 1'b1;
        rsp.needs_load  = !word.loaded;
        rsp.count_after = inc;
      end else if (ctl.lk_full) begin
        rsp.result_slot = '0;
        rsp.status      = ST_FULL;
      end else begin
        new_word.count         = COUNT_W'(1);
        new_word.loaded        = 1'b0;
        new_word.unlinked      = 1'b0;
        new_word.device_id     = req.device_id;
        new_word.object_number = req.object_number;
        wr_en                  = 1'b1;
        rsp.status             = ST_OK;
        rsp.needs_load         = 1'b1;
        rsp.count_after        = COUNT_W'(1);
      end
    end else if (ctl.oor || !held) begin
      rsp.status = ST_NOT_HELD;
    end else begin
      case (req.action)
        ACT_DUP: begin
          new_word.count  = inc;
          wr_en           = !sat;
          rsp.status      = sat ? ST_SATURATED : ST_OK;
          rsp.needs_load  = !word.loaded;
          rsp.count_after = inc;
        end
        ACT_PUT: begin
          new_word.count      = dec;
          new_word.loaded     = word.loaded && !rel;
          wr_en               = 1'b1;
          rsp.status          = ST_OK;
          rsp.needs_load      = (dec != '0) && !(word.loaded && !rel);
          rsp.release_on_disk = rel;
          rsp.count_after     = dec;
        end
        ACT_LOAD: begin
          if (!word.loaded) begin
            new_word.loaded   = 1'b1;
            new_word.unlinked = (req.link_count == '0);
            wr_en             = 1'b1;
          end
          rsp.status      = ST_OK;
          rsp.count_after = word.count;
        end
        default: begin
          rsp.status = ST_NOT_HELD;
        end
      endcase
    end
  end

endmodule

// ----- rtl/refcounted_key_cache_table.sv -----
`timescale 1ns / 1ps
// Sequence: dup, put and load pass through S_FETCH and S_EXEC before the result is registered
// (a slot beyond the table goes straight to S_EXEC); a lookup scans the entries, one entry read
// per cycle, until a match or the end, then goes to S_EXEC. One request at a time: in_stall
// stays high until the result is registered. The output register lets the result wait while
// the next request is taken. After reset a clearing pass zeroes every entry with in_stall high.
// ----------------------------------------------------------------------------
// Reference-counted key cache table
// Sequencer that scans the entry memory for lookups, fetches addressed
// entries, and updates them through the shared evaluation unit.
// ----------------------------------------------------------------------------
module refcounted_key_cache_table #(
  parameter int ENTRIES = rkc_pkg::ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rkc_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output rkc_pkg::out_rsp_t out_rsp
);
  import rkc_pkg::*;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int WIDE_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FETCH = 5'b01000,
    S_EXEC  = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  in_req_t    req_r, req_nxt;
  logic [CNT_W-1:0] issue_idx_r, issue_idx_nxt;
  logic [CNT_W-1:0] clr_idx_r, clr_idx_nxt;
  logic       chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic       have_free_r, have_free_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0] tgt_r, tgt_nxt;
  entry_t     word_r, word_nxt;
  logic       lk_hit_r, lk_hit_nxt;
  logic       lk_full_r, lk_full_nxt;
  logic       oor_r, oor_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_rsp_t   out_rsp_r, out_rsp_nxt;

  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  entry_t           ram_wr_data;
  logic             ram_rd_en;
  logic [IDX_W-1:0] ram_rd_addr;
  entry_t           ram_rd_data;

  eval_ctl_t  ev_ctl;
  entry_t     ev_word;
  logic       ev_match;
  logic       ev_wr_en;
  entry_t     ev_new_word;
  out_rsp_t   ev_rsp;

  logic [WIDE_W-1:0] slot_w;
  logic              slot_ok;

  rkc_entry_ram #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  rkc_eval_unit u_eval (
    .ctl      (ev_ctl),
    .req      (req_r),
    .word     (ev_word),
    .match    (ev_match),
    .wr_en    (ev_wr_en),
    .new_word (ev_new_word),
    .rsp      (ev_rsp)
  );

  assign slot_w  = WIDE_W'(in_req.slot);
  assign slot_ok = (slot_w < WIDE_W'(ENTRIES));

  assign ev_word         = (state_r == S_SCAN) ? ram_rd_data : word_r;
  assign ev_ctl.lk_hit   = lk_hit_r;
  assign ev_ctl.lk_full  = lk_full_r;
  assign ev_ctl.oor      = oor_r;
  assign ev_ctl.tgt_slot = (req_r.action == ACT_LOOKUP) ? SLOT_W'(tgt_r) : req_r.slot;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    issue_idx_nxt = issue_idx_r;
    clr_idx_nxt   = clr_idx_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    have_free_nxt = have_free_r;
    free_idx_nxt  = free_idx_r;
    tgt_nxt       = tgt_r;
    word_nxt      = word_r;
    lk_hit_nxt    = lk_hit_r;
    lk_full_nxt   = lk_full_r;
    oor_nxt       = oor_r;
    out_valid_nxt = out_valid_r;
    out_rsp_nxt   = out_rsp_r;

    ram_wr_en   = 1'b0;
    ram_wr_addr = tgt_r;
    ram_wr_data = ev_new_word;
    ram_rd_en   = 1'b0;
    ram_rd_addr = issue_idx_r[IDX_W-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_idx_r[IDX_W-1:0];
        ram_wr_data = '0;
        clr_idx_nxt = clr_idx_r + CNT_W'(1);
        if (clr_idx_r == CNT_W'(ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt       = in_req;
          lk_hit_nxt    = 1'b0;
          lk_full_nxt   = 1'b0;
          oor_nxt       = 1'b0;
          issue_idx_nxt = '0;
          chk_vld_nxt   = 1'b0;
          have_free_nxt = 1'b0;
          if (in_req.action == ACT_LOOKUP) begin
            state_nxt = S_SCAN;
          end else if (slot_ok) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = slot_w[IDX_W-1:0];
            tgt_nxt     = slot_w[IDX_W-1:0];
            state_nxt   = S_FETCH;
          end else begin
            oor_nxt   = 1'b1;
            state_nxt = S_EXEC;
          end
        end
      end
      S_SCAN: begin
        if (issue_idx_r != CNT_W'(ENTRIES)) begin
          ram_rd_en     = 1'b1;
          issue_idx_nxt = issue_idx_r + CNT_W'(1);
          chk_vld_nxt   = 1'b1;
          chk_idx_nxt   = issue_idx_r[IDX_W-1:0];
        end else begin
          chk_vld_nxt = 1'b0;
        end
        if (chk_vld_r && ev_match) begin
          lk_hit_nxt = 1'b1;
          tgt_nxt    = chk_idx_r;
          word_nxt   = ram_rd_data;
          state_nxt  = S_EXEC;
        end else begin
          if (chk_vld_r && (ram_rd_data.count == '0) && !have_free_r) begin
            have_free_nxt = 1'b1;
            free_idx_nxt  = chk_idx_r;
          end
          if (!chk_vld_r && (issue_idx_r == CNT_W'(ENTRIES))) begin
            tgt_nxt     = free_idx_r;
            lk_full_nxt = !have_free_r;
            state_nxt   = S_EXEC;
          end
        end
      end
      S_FETCH: begin
        word_nxt  = ram_rd_data;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          ram_wr_en     = ev_wr_en;
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = ev_rsp;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
      have_free_r <= 1'b0;
      lk_hit_r    <= 1'b0;
      lk_full_r   <= 1'b0;
      oor_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      chk_vld_r   <= chk_vld_nxt;
      have_free_r <= have_free_nxt;
      lk_hit_r    <= lk_hit_nxt;
      lk_full_r   <= lk_full_nxt;
      oor_r       <= oor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    issue_idx_r <= issue_idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    tgt_r       <= tgt_nxt;
    word_r      <= word_nxt;
    out_rsp_r   <= out_rsp_nxt;
  end

endmodule

// ----- rtl/rkc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reference-counted key cache table checker
// Port-level checks on handshake hold and on response field consistency.
// ----------------------------------------------------------------------------
module rkc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input rkc_pkg::out_rsp_t out_rsp
);
  import rkc_pkg::*;

  // hold a stalled response
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("stalled response changed");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status == ST_FULL) |->
      !out_rsp.hit && (out_rsp.count_after == '0) && (out_rsp.result_slot == '0))
    else $error("table full response carries data");

  a_not_held_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status == ST_NOT_HELD) |->
      !out_rsp.hit && !out_rsp.needs_load && !out_rsp.release_on_disk &&
      (out_rsp.count_after == '0))
    else $error("not-held response carries data");

  a_release_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.release_on_disk |->
      (out_rsp.count_after == '0) && !out_rsp.hit && (out_rsp.status == ST_OK))
    else $error("disk release on a held entry");

endmodule

bind refcounted_key_cache_table rkc_checker u_rkc_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reference-counted key cache table testbench
// Drives lookup, dup, put and load requests through the valid/stall channels,
// predicts every response from a shadow copy of the entry table, and checks
// each response field by field. Covers directed corner cases, a full table,
// a long output hold-off and a long random mix.
// ----------------------------------------------------------------------------
module tb;
  import rkc_pkg::*;

  localparam int ENTRIES        = ENTRIES_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_PRINTED    = 40;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_stall;
  out_rsp_t out_rsp;

  refcounted_key_cache_table #(
    .ENTRIES(ENTRIES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp  (out_rsp)
  );

  // shadow entry table
  logic [COUNT_W-1:0] tbl_count    [ENTRIES];
  logic               tbl_loaded   [ENTRIES];
  logic               tbl_unlinked [ENTRIES];
  logic [DEV_W-1:0]   tbl_dev      [ENTRIES];
  logic [OBJ_W-1:0]   tbl_obj      [ENTRIES];

  out_rsp_t pending_rsp[$];

  int n_errors;
  int n_sent;
  int n_checked;
  int n_lookup;
  int n_hit;
  int n_full;
  int n_dup;
  int n_put;
  int n_release;
  int n_load;
  int n_not_held;
  int n_sat;

  int tx_burst_left;
  bit tx_gaps_on;
  int hold_req;
  int hold_left;
  int pat_mode;
  int pat_left;
  int run_left;
  bit rx_quiet;
  int idle_cycles;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic out_rsp_t predict_rsp(input in_req_t r);
    out_rsp_t rsp;
    int       free_idx;
    int       s;
    rsp      = '0;
    free_idx = -1;
    s        = r.slot;
    if (r.action == ACT_LOOKUP) begin
      n_lookup++;
      for (int i = 0; i < ENTRIES; i++) begin
        if (tbl_count[i] != 0 && tbl_dev[i] == r.device_id &&
            tbl_obj[i] == r.object_number) begin
          n_hit++;
          rsp.result_slot = i[SLOT_W-1:0];
          rsp.hit         = 1'b1;
          if (tbl_count[i] == COUNT_MAX) begin
            rsp.status = ST_SATURATED;
            n_sat++;
          end else begin
            tbl_count[i] = tbl_count[i] + 1'b1;
          end
          rsp.needs_load  = !tbl_loaded[i];
          rsp.count_after = tbl_count[i];
          return rsp;
        end
        if (free_idx < 0 && tbl_count[i] == 0) free_idx = i;
      end
      if (free_idx < 0) begin
        n_full++;
        rsp.status = ST_FULL;
        return rsp;
      end
      tbl_dev[free_idx]      = r.device_id;
      tbl_obj[free_idx]      = r.object_number;
      tbl_count[free_idx]    = COUNT_W'(1);
      tbl_loaded[free_idx]   = 1'b0;
      tbl_unlinked[free_idx] = 1'b0;
      rsp.result_slot        = free_idx[SLOT_W-1:0];
      rsp.needs_load         = 1'b1;
      rsp.count_after        = COUNT_W'(1);
      return rsp;
    end
    rsp.result_slot = r.slot;
    if (s >= ENTRIES || tbl_count[s] == 0) begin
      n_not_held++;
      rsp.status = ST_NOT_HELD;
      return rsp;
    end
    case (r.action)
      ACT_DUP: begin
        n_dup++;
        if (tbl_count[s] == COUNT_MAX) begin
          rsp.status = ST_SATURATED;
          n_sat++;
        end else begin
          tbl_count[s] = tbl_count[s] + 1'b1;
        end
        rsp.needs_load = !tbl_loaded[s];
      end
      ACT_PUT: begin
        n_put++;
        if (tbl_count[s] == 1 && tbl_loaded[s] && tbl_unlinked[s]) begin
          rsp.release_on_disk = 1'b1;
          tbl_loaded[s]       = 1'b0;
          n_release++;
        end
        tbl_count[s]   = tbl_count[s] - 1'b1;
        rsp.needs_load = (tbl_count[s] != 0) && !tbl_loaded[s];
      end
      default: begin
        n_load++;
        if (!tbl_loaded[s]) begin
          tbl_loaded[s]   = 1'b1;
          tbl_unlinked[s] = (r.link_count == 0);
        end
      end
    endcase
    rsp.count_after = tbl_count[s];
    return rsp;
  endfunction

  function automatic in_req_t make_req(input logic [1:0] act, input logic [DEV_W-1:0] dev,
                                       input logic [OBJ_W-1:0] obj,
                                       input logic [SLOT_W-1:0] slot,
                                       input logic [LINK_W-1:0] links);
    in_req_t r;
    r.action        = act;
    r.device_id     = dev;
    r.object_number = obj;
    r.slot          = slot;
    r.link_count    = links;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    if (n_errors <= MAX_PRINTED)
      $display("MISMATCH response %0d %s: got %0h want %0h", n_checked, what, got, want);
  endtask

  // enter at a falling edge, leave at a falling edge
  task automatic send_req(input in_req_t r);
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    pending_rsp.push_back(predict_rsp(r));
    n_sent++;
    @(negedge clk);
    if (tx_gaps_on) begin
      if (tx_burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        tx_burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
      end else begin
        tx_burst_left--;
      end
    end
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : check_rsp
    out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected response", out_rsp, 0);
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp.result_slot !== want.result_slot)
          report_mismatch("result_slot", out_rsp.result_slot, want.result_slot);
        if (out_rsp.status !== want.status)
          report_mismatch("status", out_rsp.status, want.status);
        if (out_rsp.hit !== want.hit)
          report_mismatch("hit", out_rsp.hit, want.hit);
        if (out_rsp.needs_load !== want.needs_load)
          report_mismatch("needs_load", out_rsp.needs_load, want.needs_load);
        if (out_rsp.release_on_disk !== want.release_on_disk)
          report_mismatch("release_on_disk", out_rsp.release_on_disk, want.release_on_disk);
        if (out_rsp.count_after !== want.count_after)
          report_mismatch("count_after", out_rsp.count_after, want.count_after);
      end
      n_checked++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n || rx_quiet) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_req - 1;
      hold_req  = 0;
    end else begin
      if (pat_left == 0) begin
        pat_mode = $urandom_range(0, 2);
        pat_left = $urandom_range(20, 200);
      end
      pat_left--;
      case (pat_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 35);
        default: begin
          if (run_left > 0) begin
            out_stall <= 1'b1;
            run_left--;
          end else if ($urandom_range(0, 99) < 10) begin
            out_stall <= 1'b1;
            run_left = $urandom_range(0, 9);
          end else begin
            out_stall <= 1'b0;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request or response moved for %0d cycles", idle_cycles);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  task automatic test_basic_actions();
    send_req(make_req(ACT_LOOKUP, 8'h00, 32'h0000_0000, 6'h3F, 16'hFFFF));
    send_req(make_req(ACT_LOOKUP, 8'hFF, 32'hFFFF_FFFF, 6'h00, 16'h0000));
    send_req(make_req(ACT_LOOKUP, 8'h00, 32'h0000_0000, 6'h2A, 16'h5555));
    send_req(make_req(ACT_DUP,    8'hA5, 32'h5A5A_5A5A, 6'd0, 16'hAAAA));
    send_req(make_req(ACT_LOAD,   8'h00, 32'h0000_0000, 6'd0, 16'h0000));
    send_req(make_req(ACT_LOAD,   8'h00, 32'h0000_0000, 6'd0, 16'hFFFF));
    send_req(make_req(ACT_LOAD,   8'h00, 32'h0000_0000, 6'd1, 16'hFFFF));
    send_req(make_req(ACT_DUP,    8'h00, 32'h0000_0000, 6'd1, 16'h0000));
    send_req(make_req(ACT_PUT,    8'h00, 32'h0000_0000, 6'd0, 16'h0000));
    send_req(make_req(ACT_PUT,    8'h00, 32'h0000_0000, 6'd0, 16'h0000));
    send_req(make_req(ACT_PUT,    8'h00, 32'h0000_0000, 6'd0, 16'h0000));
    send_req(make_req(ACT_PUT,    8'h00, 32'h0000_0000, 6'd0, 16'h0000));
    send_req(make_req(ACT_DUP,    8'h00, 32'h0000_0000, 6'h3F, 16'h0000));
    send_req(make_req(ACT_LOAD,   8'h00, 32'h0000_0000, 6'h3F, 16'h0000));
    send_req(make_req(ACT_PUT,    8'h00, 32'h0000_0000, 6'h3F, 16'h0000));
    send_req(make_req(ACT_PUT,    8'h00, 32'h0000_0000, 6'd1, 16'h0000));
    send_req(make_req(ACT_PUT,    8'h00, 32'h0000_0000, 6'd1, 16'h0000));
    send_req(make_req(ACT_LOOKUP, 8'h00, 32'h0000_0000, 6'd0, 16'h0000));
    send_req(make_req(ACT_LOOKUP, 8'h12, 32'h8000_0001, 6'd0, 16'h0000));
    send_req(make_req(ACT_PUT,    8'h00, 32'h0000_0000, 6'd0, 16'h0000));
    send_req(make_req(ACT_PUT,    8'h00, 32'h0000_0000, 6'd1, 16'h0000));
    end_burst();
  endtask

  task automatic test_table_full();
    for (int i = 0; i < ENTRIES; i++)
      send_req(make_req(ACT_LOOKUP, i[DEV_W-1:0], 32'hA5A5_0000 | i, 6'd0, 16'd0));
    send_req(make_req(ACT_LOOKUP, 8'hEE, 32'hDEAD_BEEF, 6'd0, 16'd0));
    send_req(make_req(ACT_LOOKUP, 8'd5, 32'hA5A5_0005, 6'd0, 16'd0));
    send_req(make_req(ACT_PUT, 8'd0, 32'd0, 6'd9, 16'd0));
    send_req(make_req(ACT_LOOKUP, 8'hEE, 32'hDEAD_BEEF, 6'd0, 16'd0));
    for (int i = 0; i < ENTRIES; i++)
      while (tbl_count[i] != 0)
        send_req(make_req(ACT_PUT, 8'd0, 32'd0, i[SLOT_W-1:0], 16'd0));
    end_burst();
  endtask

  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    hold_req   = 300;
    for (int k = 0; k < 6; k++) begin
      send_req(make_req(ACT_LOOKUP, 8'hC3, 32'h0BAD_0000 | k, 6'd0, 16'd0));
      send_req(make_req(ACT_DUP, 8'd0, 32'd0, 6'd0, 16'd0));
      send_req(make_req(ACT_PUT, 8'd0, 32'd0, 6'd0, 16'd0));
    end
    end_burst();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_mix(input int n_items);
    logic [DEV_W-1:0] dev_pool [4];
    logic [OBJ_W-1:0] obj_pool [8];
    int               held [$];
    int               w;
    in_req_t          r;
    foreach (dev_pool[i]) dev_pool[i] = DEV_W'($urandom);
    foreach (obj_pool[i]) obj_pool[i] = $urandom;
    for (int k = 0; k < n_items; k++) begin
      held.delete();
      for (int i = 0; i < ENTRIES; i++)
        if (tbl_count[i] != 0) held.push_back(i);
      w = $urandom_range(0, 99);
      if (w < 25)      r.action = ACT_LOOKUP;
      else if (w < 40) r.action = ACT_DUP;
      else if (w < 75) r.action = ACT_PUT;
      else             r.action = ACT_LOAD;
      r.device_id     = ($urandom_range(0, 4) == 0) ? DEV_W'($urandom)
                                                     : dev_pool[$urandom_range(0, 3)];
      r.object_number = ($urandom_range(0, 4) == 0) ? $urandom
                                                     : obj_pool[$urandom_range(0, 7)];
      if (held.size() != 0 && $urandom_range(0, 99) < 85)
        r.slot = SLOT_W'(held[$urandom_range(0, held.size() - 1)]);
      else
        r.slot = SLOT_W'($urandom_range(0, 63));
      r.link_count = $urandom_range(0, 1) ? '0 : LINK_W'($urandom);
      send_req(r);
    end
    end_burst();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req        = '0;
    out_stall     = 1'b0;
    tx_gaps_on    = 1'b1;
    tx_burst_left = 0;
    hold_req      = 0;
    hold_left     = 0;
    pat_mode      = 0;
    pat_left      = 0;
    run_left      = 0;
    rx_quiet      = 1'b0;
    idle_cycles   = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_count[i]    = '0;
      tbl_loaded[i]   = 1'b0;
      tbl_unlinked[i] = 1'b0;
      tbl_dev[i]      = '0;
      tbl_obj[i]      = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic_actions();
    test_table_full();
    test_backpressure();
    test_random_mix(1230);

    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (ENTRIES + 8) @(negedge clk);

    $display("run: %0d requests, %0d responses checked, %0d mismatches",
             n_sent, n_checked, n_errors);
    $display("mix: %0d lookups (%0d hits, %0d full), %0d dups, %0d puts (%0d releases),",
             n_lookup, n_hit, n_full, n_dup, n_put, n_release);
    $display("     %0d loads, %0d refused, %0d saturated", n_load, n_not_held, n_sat);
    if (n_errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
